### design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/lpmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpmr_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int ZW = 34;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_YAW = 3'd0, REG_PITCH = 3'd1, REG_ROLL = 3'd2,
    REG_TX = 3'd3, REG_TY = 3'd4, REG_TZ = 3'd5
  } reg_idx_t;

  // arctangent per step, 2^32 per turn
  function automatic logic signed [33:0] atan_lut(input int i);
    logic signed [33:0] v;
    v = '0;
    case (i)
      0: v = 34'sd536870912;  1: v = 34'sd316933406;  2: v = 34'sd167458907;
      3: v = 34'sd85004756;   4: v = 34'sd42667331;   5: v = 34'sd21354465;
      6: v = 34'sd10679838;   7: v = 34'sd5340245;    8: v = 34'sd2670163;
      9: v = 34'sd1335087;    10: v = 34'sd667544;    11: v = 34'sd333772;
      12: v = 34'sd166886;    13: v = 34'sd83443;     14: v = 34'sd41722;
      15: v = 34'sd20861;     16: v = 34'sd10430;     17: v = 34'sd5215;
      18: v = 34'sd2608;      19: v = 34'sd1304;      20: v = 34'sd652;
      21: v = 34'sd326;       22: v = 34'sd163;       23: v = 34'sd81;
      24: v = 34'sd41;        25: v = 34'sd20;        26: v = 34'sd10;
      27: v = 34'sd5;         28: v = 34'sd3;         29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // cordic vector of one lane, four lanes handed cell to cell
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic flip;
  } cvec_t;
endpackage
`default_nettype wire

### design/lpmr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lpmr_in_if #(parameter int CW = 32, parameter int AW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  logic [15:0] point_intensity;
  logic [AW-1:0] rotor_angle;
  modport source(output valid, point_x, point_y, point_z, point_intensity, rotor_angle,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, point_intensity, rotor_angle,
               output ready);
endinterface

interface lpmr_out_if #(parameter int CW = 32);
  logic valid;
  logic ready;
  logic signed [CW-1:0] world_x;
  logic signed [CW-1:0] world_y;
  logic signed [CW-1:0] world_z;
  logic [15:0] world_intensity;
  modport source(output valid, world_x, world_y, world_z, world_intensity, input ready);
  modport sink(input valid, world_x, world_y, world_z, world_intensity, output ready);
endinterface
`default_nettype wire

### design/lpmr_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one rotation step of four cordic lanes, registered, stalls with the pipe
module lpmr_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire lpmr_pkg::cvec_t v_i [4],
  output lpmr_pkg::cvec_t v_o [4]
);
  import lpmr_pkg::*;
  cvec_t v_r [4];
  cvec_t v_nxt [4];

  // micro-rotation per lane
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      v_nxt[k] = v_i[k];
      if (!v_i[k].z[ZW-1]) begin
        v_nxt[k].x = v_i[k].x - (v_i[k].y >>> STEP);
        v_nxt[k].y = v_i[k].y + (v_i[k].x >>> STEP);
        v_nxt[k].z = v_i[k].z - atan_lut(STEP);
      end else begin
        v_nxt[k].x = v_i[k].x + (v_i[k].y >>> STEP);
        v_nxt[k].y = v_i[k].y - (v_i[k].x >>> STEP);
        v_nxt[k].z = v_i[k].z + atan_lut(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end
  assign v_o = v_r;
endmodule
`default_nettype wire

### design/lidar_point_mount_rotor_transform_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Mount-and-rotor transform for lidar points. One point per clock is accepted while the output
// is not stalled, and one world point is produced per point. The pipe is 41 registers deep: a
// chain of 30 cordic cells (four sine/cosine lanes side by side: yaw, pitch, roll, rotor)
// followed by 11 stages that round the trig values, build the mount matrix, apply it, add the
// translation, rotate by the rotor angle and saturate. The whole pipeline advances only when
// its last stage is empty or being taken, so a stalled output holds all points in flight.
// Configuration must be written through cfg_we/cfg_index/cfg_data while the pipe is empty;
// the user is bound to this, and the block itself does not enforce it.
module lidar_point_mount_rotor_transform_core #(
  parameter int COORD_WIDTH = lpmr_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = lpmr_pkg::ANGLE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_data,
  lpmr_in_if.sink in_ch,
  lpmr_out_if.source out_ch
);
  import lpmr_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int TF = ((60 - CW) < 30) ? (60 - CW) : 30;
  localparam int TSH = 30 - TF;
  localparam int TW = TF + 2;          // trig value width incl. sign
  localparam int MW = CW + TW + 3;     // matrix times point sum
  localparam int NW = CW + 2;          // mounted coordinate
  localparam int QW = NW + TW + 1;     // rotor product sum
  localparam int POST = 11;
  localparam int DEPTH = CORDIC_STEPS + POST;

  // pipe control
  logic [DEPTH-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;

  // configuration registers
  logic [AW-1:0] yaw_r, pitch_r, roll_r;
  logic signed [CW-1:0] tx_r, ty_r, tz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r <= '0; pitch_r <= '0; roll_r <= '0;
      tx_r <= '0; ty_r <= '0; tz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_YAW:   yaw_r <= cfg_data[AW-1:0];
        REG_PITCH: pitch_r <= cfg_data[AW-1:0];
        REG_ROLL:  roll_r <= cfg_data[AW-1:0];
        REG_TX:    tx_r <= cfg_data[CW-1:0];
        REG_TY:    ty_r <= cfg_data[CW-1:0];
        REG_TZ:    tz_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
  end

  // angle prefold into cordic start vectors
  function automatic cvec_t prefold(input logic [AW-1:0] a);
    cvec_t v;
    logic signed [33:0] z;
    z = {{2{a[AW-1]}}, a, {(32 - AW){1'b0}}};
    v.flip = 1'b0;
    if (z > 34'sd1073741824) begin
      z = z - 34'sd2147483648; v.flip = 1'b1;
    end else if (z < -34'sd1073741824) begin
      z = z + 34'sd2147483648; v.flip = 1'b1;
    end
    v.x = CORDIC_START;
    v.y = '0;
    v.z = z;
    return v;
  endfunction

  cvec_t chain [CORDIC_STEPS+1][4];
  assign chain[0][0] = prefold(yaw_r);
  assign chain[0][1] = prefold(pitch_r);
  assign chain[0][2] = prefold(roll_r);
  assign chain[0][3] = prefold(in_ch.rotor_angle);

  // payload carried beside the cordic chain
  logic signed [CW-1:0] px_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] py_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] pz_r [CORDIC_STEPS+1];
  logic [15:0] pi_r [DEPTH];
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r[0] <= in_ch.point_x; py_r[0] <= in_ch.point_y; pz_r[0] <= in_ch.point_z;
      pi_r[0] <= in_ch.point_intensity;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        px_r[k] <= px_r[k-1]; py_r[k] <= py_r[k-1]; pz_r[k] <= pz_r[k-1];
      end
      for (int k = 1; k < DEPTH; k++) pi_r[k] <= pi_r[k-1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      lpmr_cordic_cell #(.STEP(g)) u_cell (
        .clk(clk), .en(adv), .v_i(chain[g]), .v_o(chain[g+1])
      );
    end
  endgenerate

  // cosine or sine finish: clamp, round, sign flip
  function automatic logic signed [TW-1:0] tfin(input logic signed [33:0] a, input logic f);
    logic signed [33:0] c;
    logic signed [34:0] r;
    c = (a > 34'sd1073741824) ? 34'sd1073741824 :
        (a < -34'sd1073741824) ? -34'sd1073741824 : a;
    if (TSH == 0) r = 35'(c);
    else r = (35'(c) + (35'sd1 <<< (TSH > 0 ? TSH - 1 : 0))) >>> TSH;
    if (f) r = -r;
    return TW'(r);
  endfunction

  function automatic logic signed [TW+1:0] mq(input logic signed [TW+1:0] a,
                                             input logic signed [TW+1:0] b);
    logic signed [2*TW+3:0] p;
    p = (2*TW+4)'(a) * (2*TW+4)'(b);
    p = p + ((2*TW+4)'(1) <<< (TF - 1));
    return (TW+2)'(p >>> TF);
  endfunction

  function automatic logic signed [TW-1:0] clampo(input logic signed [TW+1:0] v);
    logic signed [TW+1:0] one;
    one = (TW+2)'(1) <<< TF;
    if (v > one) return TW'(one);
    if (v < -one) return TW'(-one);
    return TW'(v);
  endfunction

  // stage a: trig values
  logic signed [TW+1:0] cy_a_r, sy_a_r, cp_a_r, sp_a_r, cr_a_r, sr_a_r, cz_a_r, sz_a_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cy_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][0].x, chain[CORDIC_STEPS][0].flip));
      sy_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][0].y, chain[CORDIC_STEPS][0].flip));
      cp_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][1].x, chain[CORDIC_STEPS][1].flip));
      sp_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][1].y, chain[CORDIC_STEPS][1].flip));
      cr_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][2].x, chain[CORDIC_STEPS][2].flip));
      sr_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][2].y, chain[CORDIC_STEPS][2].flip));
      cz_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][3].x, chain[CORDIC_STEPS][3].flip));
      sz_a_r <= (TW+2)'(tfin(chain[CORDIC_STEPS][3].y, chain[CORDIC_STEPS][3].flip));
    end
  end

  // stage b: first products
  logic signed [TW+1:0] cs_b_r, ss_b_r, r00_b_r, r10_b_r, r20_b_r, r21_b_r, r22_b_r;
  logic signed [TW+1:0] cy_b_r, sy_b_r, cr_b_r, sr_b_r, cz_b_r, sz_b_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cs_b_r <= mq(cy_a_r, sp_a_r); ss_b_r <= mq(sy_a_r, sp_a_r);
      r00_b_r <= mq(cy_a_r, cp_a_r); r10_b_r <= mq(sy_a_r, cp_a_r);
      r20_b_r <= -sp_a_r; r21_b_r <= mq(cp_a_r, sr_a_r); r22_b_r <= mq(cp_a_r, cr_a_r);
      cy_b_r <= cy_a_r; sy_b_r <= sy_a_r; cr_b_r <= cr_a_r; sr_b_r <= sr_a_r;
      cz_b_r <= cz_a_r; sz_b_r <= sz_a_r;
    end
  end

  // stage c: second products
  logic signed [TW+1:0] p1_c_r, p2_c_r, p3_c_r, p4_c_r, p5_c_r, p6_c_r, p7_c_r, p8_c_r;
  logic signed [TW-1:0] r00_c_r, r10_c_r, r20_c_r, r21_c_r, r22_c_r;
  logic signed [TW+1:0] cz_c_r, sz_c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_c_r <= mq(cs_b_r, sr_b_r); p2_c_r <= mq(sy_b_r, cr_b_r);
      p3_c_r <= mq(cs_b_r, cr_b_r); p4_c_r <= mq(sy_b_r, sr_b_r);
      p5_c_r <= mq(ss_b_r, sr_b_r); p6_c_r <= mq(cy_b_r, cr_b_r);
      p7_c_r <= mq(ss_b_r, cr_b_r); p8_c_r <= mq(cy_b_r, sr_b_r);
      r00_c_r <= clampo(r00_b_r); r10_c_r <= clampo(r10_b_r); r20_c_r <= clampo(r20_b_r);
      r21_c_r <= clampo(r21_b_r); r22_c_r <= clampo(r22_b_r);
      cz_c_r <= cz_b_r; sz_c_r <= sz_b_r;
    end
  end

  // stage d: matrix sums and clamp
  logic signed [TW-1:0] r_d_r [9];
  logic signed [TW+1:0] cz_d_r, sz_d_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      r_d_r[0] <= r00_c_r;
      r_d_r[1] <= clampo(p1_c_r - p2_c_r);
      r_d_r[2] <= clampo(p3_c_r + p4_c_r);
      r_d_r[3] <= r10_c_r;
      r_d_r[4] <= clampo(p5_c_r + p6_c_r);
      r_d_r[5] <= clampo(p7_c_r - p8_c_r);
      r_d_r[6] <= r20_c_r; r_d_r[7] <= r21_c_r; r_d_r[8] <= r22_c_r;
      cz_d_r <= cz_c_r; sz_d_r <= sz_c_r;
    end
  end

  // point delayed to meet the matrix
  logic signed [CW-1:0] pd_r [3][3];
  logic signed [TW+1:0] cz_q_r [2], sz_q_r [2];
  always_ff @(posedge clk) begin
    if (adv) begin
      pd_r[0][0] <= px_r[CORDIC_STEPS]; pd_r[1][0] <= py_r[CORDIC_STEPS];
      pd_r[2][0] <= pz_r[CORDIC_STEPS];
      for (int k = 1; k < 3; k++) begin
        for (int j = 0; j < 3; j++) pd_r[j][k] <= pd_r[j][k-1];
      end
    end
  end

  // stage e: nine products
  logic signed [MW-1:0] rp_e_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp_e_r[3*i+j] <= MW'(r_d_r[3*i+j]) * MW'(pd_r[j][2]);
        end
      end
      cz_q_r[0] <= cz_d_r; sz_q_r[0] <= sz_d_r;
    end
  end

  // stage f: row sums, round, translate
  logic signed [NW-1:0] m_f_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      m_f_r[0] <= NW'((rp_e_r[0] + rp_e_r[1] + rp_e_r[2] + (MW'(1) <<< (TF - 1))) >>> TF)
                  + NW'(tx_r);
      m_f_r[1] <= NW'((rp_e_r[3] + rp_e_r[4] + rp_e_r[5] + (MW'(1) <<< (TF - 1))) >>> TF)
                  + NW'(ty_r);
      m_f_r[2] <= NW'((rp_e_r[6] + rp_e_r[7] + rp_e_r[8] + (MW'(1) <<< (TF - 1))) >>> TF)
                  + NW'(tz_r);
      cz_q_r[1] <= cz_q_r[0]; sz_q_r[1] <= sz_q_r[0];
    end
  end

  // stage g: rotor products
  logic signed [QW-1:0] mc_g_r, ms_g_r, nc_g_r, ns_g_r;
  logic signed [NW-1:0] mz_g_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      mc_g_r <= QW'(m_f_r[0]) * QW'(cz_q_r[1]); ms_g_r <= QW'(m_f_r[1]) * QW'(sz_q_r[1]);
      nc_g_r <= QW'(m_f_r[0]) * QW'(sz_q_r[1]); ns_g_r <= QW'(m_f_r[1]) * QW'(cz_q_r[1]);
      mz_g_r <= m_f_r[2];
    end
  end

  // stage h: rotor sums rounded
  logic signed [QW-1:0] wx_h_r, wy_h_r;
  logic signed [NW-1:0] wz_h_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      wx_h_r <= (mc_g_r - ms_g_r + (QW'(1) <<< (TF - 1))) >>> TF;
      wy_h_r <= (nc_g_r + ns_g_r + (QW'(1) <<< (TF - 1))) >>> TF;
      wz_h_r <= mz_g_r;
    end
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] hi, lo;
    hi = (QW'(1) <<< (CW - 1)) - QW'(1);
    lo = -(QW'(1) <<< (CW - 1));
    if (v > hi) return CW'(hi);
    if (v < lo) return CW'(lo);
    return CW'(v);
  endfunction

  // stage i: saturate
  logic signed [CW-1:0] wx_i_r, wy_i_r, wz_i_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      wx_i_r <= sat(wx_h_r); wy_i_r <= sat(wy_h_r); wz_i_r <= sat(QW'(wz_h_r));
    end
  end

  // stages j,k: output register pair
  logic signed [CW-1:0] ox_r, oy_r, oz_r;
  logic signed [CW-1:0] qx_r, qy_r, qz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r <= wx_i_r; qy_r <= wy_i_r; qz_r <= wz_i_r;
      ox_r <= qx_r; oy_r <= qy_r; oz_r <= qz_r;
    end
  end

  assign out_ch.valid = vld_r[DEPTH-1];
  assign out_ch.world_x = ox_r;
  assign out_ch.world_y = oy_r;
  assign out_ch.world_z = oz_r;
  assign out_ch.world_intensity = pi_r[DEPTH-1];

  `ASSERT_CLK(a_ready_adv, clk, rst_n, in_ch.ready == (!out_ch.valid || out_ch.ready),
              "ready does not follow output stall")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
               out_ch.valid && $stable(out_ch.world_x), "stalled result lost")
  `ASSERT_NEXT(a_flow, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0],
               "accepted beat not in pipe")
endmodule
`default_nettype wire
